// ===== src/slipf_pkg.sv =====
package slipf_pkg;

  // Queue between the checksum front end and the SLIP serializer
  localparam int QUEUE_DEPTH_DEF = 2;

  // SLIP framing bytes
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Fixed packet fields
  localparam logic [7:0] IP_VER_IHL   = 8'h45;
  localparam logic [7:0] IP_TOS       = 8'h00;
  localparam logic [7:0] IP_TOTAL_LEN = 8'd33;
  localparam logic [7:0] IP_PROTO_UDP = 8'd17;
  localparam logic [7:0] UDP_LEN      = 8'd13;

  // Constant parts of both checksums, pre-added:
  // IP:  0x4500 + 33 + protocol 17 (TTL is added on its own)
  // UDP: protocol 17 + UDP length twice (pseudo-header and header)
  localparam logic [15:0] IP_SUM_CONST  = 16'h4532;
  localparam logic [15:0] UDP_SUM_CONST = 16'd43;

  // Checksum accumulation: one term per cycle, ten terms
  localparam int          SUM_W    = 20;
  localparam int          STEP_W   = 4;
  localparam logic [3:0]  SUM_LAST = 4'd9;

  // Serializer: opening END, 33 packet bytes, closing END
  localparam int          RES_W    = 6;
  localparam logic [5:0]  RES_LAST = 6'd34;

  typedef enum logic [2:0] {
    REG_SRC_ADDR   = 3'd0,
    REG_DST_ADDR   = 3'd1,
    REG_SRC_PORT   = 3'd2,
    REG_DST_PORT   = 3'd3,
    REG_DEVICE_ID  = 3'd4,
    REG_TTL        = 3'd5,
    REG_IDENT      = 3'd6,
    REG_FLAGS_FRAG = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  device_id;
    logic [7:0]  ttl;
    logic [15:0] ident;
    logic [15:0] flags_frag;
  } cfg_t;

  // One packet ready for serialization
  typedef struct packed {
    logic [15:0] ip_ck;
    logic [15:0] udp_ck;
    logic [7:0]  accel_x;
    logic [7:0]  accel_y;
    logic [7:0]  accel_z;
    logic [7:0]  temperature;
  } pkt_t;

  // Fold end-around carries of a 20-bit sum and invert.
  function automatic logic [15:0] fold_ck(input logic [SUM_W-1:0] s);
    logic [16:0] t;
    logic [15:0] f;
    t = {1'b0, s[15:0]} + {13'd0, s[SUM_W-1:16]};
    f = t[15:0] + {15'd0, t[16]};
    return ~f;
  endfunction

endpackage

// ===== src/udp_ip_packet_slip_framer.sv =====
// Sensor report to SLIP-framed IPv4/UDP packet. Each input item is one
// four-byte report (accel_x in the low byte of in_tdata up to temperature in
// the top byte). The block wraps it in a 33-byte packet: a 20-byte IPv4 header
// (version 4, IHL 5, total length 33, protocol UDP, with the header checksum)
// and an 8-byte UDP header (length 13, checksum over the pseudo-header and
// payload, zero sent as 0xFFFF), then device_id and the four report bytes. The
// packet leaves as 35 result items: an opening END (0xC0), the 33 packet bytes
// and a closing END flagged by out_tlast. A packet byte equal to END or ESC
// leaves as one item carrying the two-byte escape, marked by out_tuser; its
// bytes sit in out_tdata[7:0] then out_tdata[15:8]. The serializer sends one
// result item per cycle while a packet waits and out_tready does not hold it
// off, which sets the sustained rate. The checksum front end runs ahead,
// parking finished packets in a QUEUE_DEPTH-deep queue, so input and output
// stall independently. Write configuration registers only while no packet is
// in flight; addresses, ports, TTL, ident and flags are read live while a
// packet is built and sent.
module udp_ip_packet_slip_framer #(
  parameter int QUEUE_DEPTH = slipf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // accel_x, accel_y, accel_z, temperature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // first_byte, second_byte
  output logic        out_tuser,  // pair_valid
  output logic        out_tlast   // frame_end
);
  import slipf_pkg::*;

  cfg_t cfg_r;
  pkt_t push_entry;
  pkt_t head_entry;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // Configuration registers; hold their value between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_addr   <= 32'd0;
      cfg_r.dst_addr   <= 32'd0;
      cfg_r.src_port   <= 16'd0;
      cfg_r.dst_port   <= 16'd0;
      cfg_r.device_id  <= 8'd3;
      cfg_r.ttl        <= 8'd64;
      cfg_r.ident      <= 16'd0;
      cfg_r.flags_frag <= 16'd0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_addr))
        REG_SRC_ADDR:   cfg_r.src_addr   <= cfg_wdata;
        REG_DST_ADDR:   cfg_r.dst_addr   <= cfg_wdata;
        REG_SRC_PORT:   cfg_r.src_port   <= cfg_wdata[15:0];
        REG_DST_PORT:   cfg_r.dst_port   <= cfg_wdata[15:0];
        REG_DEVICE_ID:  cfg_r.device_id  <= cfg_wdata[7:0];
        REG_TTL:        cfg_r.ttl        <= cfg_wdata[7:0];
        REG_IDENT:      cfg_r.ident      <= cfg_wdata[15:0];
        REG_FLAGS_FRAG: cfg_r.flags_frag <= cfg_wdata[15:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front: take reports, accumulate both checksums one term per cycle
  slipf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // Finished packets wait here for the serializer
  slipf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  // Back: walk the packet byte by byte, escape, frame, register the output
  slipf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .empty_i    (empty),
    .entry_i    (head_entry),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/slipf_front.sv =====
module slipf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  slipf_pkg::cfg_t   cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // accel_x, accel_y, accel_z, temperature
  input  logic              full_i,
  output logic              push_o,
  output slipf_pkg::pkt_t   entry_o
);
  import slipf_pkg::*;

  logic              hold_vld_r, hold_vld_nxt;
  logic [31:0]       hold_data_r;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  ip_acc_r, udp_acc_r;
  logic [31:0]       pay_r;
  logic [15:0]       ip_term, udp_term;
  logic [15:0]       udp_ck;
  logic              start;

  assign push_o    = done_r && !full_i;
  assign start     = hold_vld_r && !busy_r && (!done_r || push_o);
  assign in_tready = !hold_vld_r || start;

  // Pick this cycle's term for each checksum
  always_comb begin
    ip_term  = '0;
    udp_term = '0;
    case (cnt_r)
      4'd0: begin
        ip_term  = IP_SUM_CONST;
        udp_term = UDP_SUM_CONST;
      end
      4'd1: begin
        ip_term  = cfg.ident;
        udp_term = cfg.src_addr[31:16];
      end
      4'd2: begin
        ip_term  = cfg.flags_frag;
        udp_term = cfg.src_addr[15:0];
      end
      4'd3: begin
        ip_term  = {cfg.ttl, 8'h00};
        udp_term = cfg.dst_addr[31:16];
      end
      4'd4: begin
        ip_term  = cfg.src_addr[31:16];
        udp_term = cfg.dst_addr[15:0];
      end
      4'd5: begin
        ip_term  = cfg.src_addr[15:0];
        udp_term = cfg.src_port;
      end
      4'd6: begin
        ip_term  = cfg.dst_addr[31:16];
        udp_term = cfg.dst_port;
      end
      4'd7: begin
        ip_term  = cfg.dst_addr[15:0];
        udp_term = {cfg.device_id, pay_r[7:0]};
      end
      4'd8: begin
        udp_term = {pay_r[15:8], pay_r[23:16]};
      end
      4'd9: begin
        udp_term = {pay_r[31:24], 8'h00};
      end
      default: begin
        ip_term  = '0;
        udp_term = '0;
      end
    endcase
  end

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    busy_nxt     = busy_r;
    done_nxt     = done_r;
    cnt_nxt      = cnt_r;
    if (start) begin
      hold_vld_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      hold_vld_nxt = 1'b1;
    end
    if (push_o) begin
      done_nxt = 1'b0;
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == SUM_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      busy_r     <= busy_nxt;
      done_r     <= done_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_data_r <= in_tdata;
    end
    if (start) begin
      pay_r     <= hold_data_r;
      ip_acc_r  <= '0;
      udp_acc_r <= '0;
    end else if (busy_r) begin
      ip_acc_r  <= ip_acc_r + {{(SUM_W-16){1'b0}}, ip_term};
      udp_acc_r <= udp_acc_r + {{(SUM_W-16){1'b0}}, udp_term};
    end
  end

  // A UDP checksum of zero goes out as all ones
  always_comb begin
    udp_ck = fold_ck(udp_acc_r);
    if (udp_ck == 16'h0000) begin
      udp_ck = 16'hFFFF;
    end
  end

  assign entry_o.ip_ck       = fold_ck(ip_acc_r);
  assign entry_o.udp_ck      = udp_ck;
  assign entry_o.accel_x     = pay_r[7:0];
  assign entry_o.accel_y     = pay_r[15:8];
  assign entry_o.accel_z     = pay_r[23:16];
  assign entry_o.temperature = pay_r[31:24];

`ifndef ASSERT_OFF
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("front summing and holding a finished packet at once");
`endif

endmodule

// ===== src/slipf_fifo.sv =====
module slipf_fifo #(
  parameter int DEPTH = slipf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  slipf_pkg::pkt_t   entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output slipf_pkg::pkt_t   head_o
);
  import slipf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pkt_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && full_o |-> pop_i)
    else $error("packet queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("packet queue read while empty");
`endif

endmodule

// ===== src/slipf_back.sv =====
module slipf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  slipf_pkg::cfg_t   cfg,
  input  logic              empty_i,
  input  slipf_pkg::pkt_t   entry_i,
  output logic              pop_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // first_byte, second_byte
  output logic              out_tuser,  // pair_valid
  output logic              out_tlast   // frame_end
);
  import slipf_pkg::*;

  logic [RES_W-1:0] idx_r, idx_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [7:0]       first_r, second_r;
  logic             pair_r, last_r;
  logic [7:0]       pkt_byte;
  logic [7:0]       first_nxt, second_nxt;
  logic             pair_nxt;
  logic             in_pkt;
  logic             adv;

  assign adv   = !empty_i && (!out_vld_r || out_tready);
  assign pop_o = adv && (idx_r == RES_LAST);

  // Packet byte at position idx_r - 1; the two frame ends read as END
  always_comb begin
    case (idx_r)
      6'd1:    pkt_byte = IP_VER_IHL;
      6'd2:    pkt_byte = IP_TOS;
      6'd3:    pkt_byte = 8'h00;
      6'd4:    pkt_byte = IP_TOTAL_LEN;
      6'd5:    pkt_byte = cfg.ident[15:8];
      6'd6:    pkt_byte = cfg.ident[7:0];
      6'd7:    pkt_byte = cfg.flags_frag[15:8];
      6'd8:    pkt_byte = cfg.flags_frag[7:0];
      6'd9:    pkt_byte = cfg.ttl;
      6'd10:   pkt_byte = IP_PROTO_UDP;
      6'd11:   pkt_byte = entry_i.ip_ck[15:8];
      6'd12:   pkt_byte = entry_i.ip_ck[7:0];
      6'd13:   pkt_byte = cfg.src_addr[31:24];
      6'd14:   pkt_byte = cfg.src_addr[23:16];
      6'd15:   pkt_byte = cfg.src_addr[15:8];
      6'd16:   pkt_byte = cfg.src_addr[7:0];
      6'd17:   pkt_byte = cfg.dst_addr[31:24];
      6'd18:   pkt_byte = cfg.dst_addr[23:16];
      6'd19:   pkt_byte = cfg.dst_addr[15:8];
      6'd20:   pkt_byte = cfg.dst_addr[7:0];
      6'd21:   pkt_byte = cfg.src_port[15:8];
      6'd22:   pkt_byte = cfg.src_port[7:0];
      6'd23:   pkt_byte = cfg.dst_port[15:8];
      6'd24:   pkt_byte = cfg.dst_port[7:0];
      6'd25:   pkt_byte = 8'h00;
      6'd26:   pkt_byte = UDP_LEN;
      6'd27:   pkt_byte = entry_i.udp_ck[15:8];
      6'd28:   pkt_byte = entry_i.udp_ck[7:0];
      6'd29:   pkt_byte = cfg.device_id;
      6'd30:   pkt_byte = entry_i.accel_x;
      6'd31:   pkt_byte = entry_i.accel_y;
      6'd32:   pkt_byte = entry_i.accel_z;
      6'd33:   pkt_byte = entry_i.temperature;
      default: pkt_byte = SLIP_END;
    endcase
  end

  assign in_pkt = (idx_r != '0) && (idx_r != RES_LAST);

  // Escape END and ESC inside the packet
  always_comb begin
    first_nxt  = pkt_byte;
    second_nxt = 8'h00;
    pair_nxt   = 1'b0;
    if (in_pkt && pkt_byte == SLIP_END) begin
      first_nxt  = SLIP_ESC;
      second_nxt = SLIP_ESC_END;
      pair_nxt   = 1'b1;
    end else if (in_pkt && pkt_byte == SLIP_ESC) begin
      first_nxt  = SLIP_ESC;
      second_nxt = SLIP_ESC_ESC;
      pair_nxt   = 1'b1;
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      idx_nxt     = (idx_r == RES_LAST) ? '0 : idx_r + 1'b1;
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      pair_r   <= pair_nxt;
      last_r   <= (idx_r == RES_LAST);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {second_r, first_r};
  assign out_tuser  = pair_r;
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0 |-> !empty_i)
    else $error("queue head lost in the middle of a frame");
  a_pair_is_escape: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && pair_r |-> first_r == SLIP_ESC && !last_r)
    else $error("escape pair without ESC lead byte");
`endif

endmodule

// ===== tb/sv/slipf_scoreboard_pkg.sv =====
package slipf_scoreboard_pkg;
  import slipf_pkg::*;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       pair_valid;
    logic       frame_end;
  } serial_item_t;

  class slip_scoreboard;
    cfg_t         regs;
    serial_item_t serial_expect_q[$];
    int           errors;
    int           checked;

    function new();
      regs           = '0;
      regs.device_id = 8'd3;
      regs.ttl       = 8'd64;
      errors         = 0;
      checked        = 0;
    endfunction

    function logic [15:0] fold16(logic [31:0] s);
      while (s[31:16] != 16'd0)
        s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return s[15:0];
    endfunction

    // Folded, not yet inverted, UDP sum for one report.
    function logic [15:0] udp_fold(logic [31:0] d);
      logic [31:0] sum;
      sum = 32'(regs.src_addr[31:16]) + 32'(regs.src_addr[15:0])
          + 32'(regs.dst_addr[31:16]) + 32'(regs.dst_addr[15:0])
          + 32'(IP_PROTO_UDP) + 32'(UDP_LEN) + 32'(UDP_LEN)
          + 32'(regs.src_port) + 32'(regs.dst_port)
          + 32'({regs.device_id, d[7:0]}) + 32'({d[15:8], d[23:16]})
          + 32'({d[31:24], 8'h00});
      return fold16(sum);
    endfunction

    // Search a report whose UDP checksum comes out as zero.
    function logic [31:0] zero_udp_report();
      logic [31:0] d;
      d = '0;
      for (int v = 0; v < 65536; v++) begin
        d = {8'h00, v[7:0], v[15:8], 8'h00};
        if (udp_fold(d) == 16'hFFFF)
          return d;
      end
      return d;
    endfunction

    // Build the packet for one report and queue its SLIP-encoded items.
    function void frame_report(logic [31:0] d);
      logic [15:0] w [10];
      logic [7:0]  pkt [33];
      logic [31:0] sum;
      logic [15:0] udp_ck;
      serial_item_t it;
      w[0] = {IP_VER_IHL, IP_TOS};
      w[1] = {8'h00, IP_TOTAL_LEN};
      w[2] = regs.ident;
      w[3] = regs.flags_frag;
      w[4] = {regs.ttl, IP_PROTO_UDP};
      w[5] = 16'h0000;
      w[6] = regs.src_addr[31:16];
      w[7] = regs.src_addr[15:0];
      w[8] = regs.dst_addr[31:16];
      w[9] = regs.dst_addr[15:0];
      sum = '0;
      for (int i = 0; i < 10; i++)
        sum = sum + 32'(w[i]);
      w[5] = ~fold16(sum);
      udp_ck = ~udp_fold(d);
      // zero would mean "no checksum", so send all ones
      if (udp_ck == 16'h0000)
        udp_ck = 16'hFFFF;
      for (int i = 0; i < 10; i++) begin
        pkt[2*i]   = w[i][15:8];
        pkt[2*i+1] = w[i][7:0];
      end
      {pkt[20], pkt[21]} = regs.src_port;
      {pkt[22], pkt[23]} = regs.dst_port;
      {pkt[24], pkt[25]} = {8'h00, UDP_LEN};
      {pkt[26], pkt[27]} = udp_ck;
      pkt[28] = regs.device_id;
      pkt[29] = d[7:0];
      pkt[30] = d[15:8];
      pkt[31] = d[23:16];
      pkt[32] = d[31:24];
      serial_expect_q.push_back('{SLIP_END, 8'h00, 1'b0, 1'b0});
      for (int i = 0; i < 33; i++) begin
        if (pkt[i] == SLIP_END)
          it = '{SLIP_ESC, SLIP_ESC_END, 1'b1, 1'b0};
        else if (pkt[i] == SLIP_ESC)
          it = '{SLIP_ESC, SLIP_ESC_ESC, 1'b1, 1'b0};
        else
          it = '{pkt[i], 8'h00, 1'b0, 1'b0};
        serial_expect_q.push_back(it);
      end
      serial_expect_q.push_back('{SLIP_END, 8'h00, 1'b0, 1'b1});
    endfunction

    function void check_serial_item(logic [15:0] tdata, logic tuser, logic tlast);
      serial_item_t want;
      serial_item_t got;
      got = '{tdata[7:0], tdata[15:8], tuser, tlast};
      checked++;
      if (serial_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h %h pair %b end %b", $time,
                 got.first_byte, got.second_byte, got.pair_valid, got.frame_end);
        return;
      end
      want = serial_expect_q.pop_front();
      if (got.first_byte !== want.first_byte || got.second_byte !== want.second_byte ||
          got.pair_valid !== want.pair_valid || got.frame_end !== want.frame_end) begin
        errors++;
        $display("%0t: item %0d expected %h %h pair %b end %b, got %h %h pair %b end %b",
                 $time, checked, want.first_byte, want.second_byte, want.pair_valid,
                 want.frame_end, got.first_byte, got.second_byte, got.pair_valid,
                 got.frame_end);
      end
    endfunction

    function int pending();
      return serial_expect_q.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_udp_ip_packet_slip_framer.sv =====
module tb_udp_ip_packet_slip_framer;
  import slipf_pkg::*;
  import slipf_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  // Front end plus queue plus serializer start; pad generously.
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 37;
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // accel_x, accel_y, accel_z, temperature
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // first_byte, second_byte
  logic        out_tuser;        // pair_valid
  logic        out_tlast;        // frame_end

  slip_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  udp_ip_packet_slip_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: hold off for a requested stretch, otherwise stall at the phase rate.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every item the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_serial_item(out_tdata, out_tuser, out_tlast);
  end

  // Favor the two SLIP control bytes so escapes show up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return SLIP_END;
      1: return SLIP_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_report();
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  // Offer one report, idling first at the phase rate; return on acceptance.
  task automatic send_report(input logic [31:0] d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.frame_report(d);
  endtask

  // Drop valid, wait for every queued item, then let the pipeline settle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers, one per cycle; the block must be idle.
  task automatic apply_config(input cfg_t c);
    reg_idx_t    idx;
    logic [31:0] v;
    idx = idx.first();
    do begin
      case (idx)
        REG_SRC_ADDR:   v = c.src_addr;
        REG_DST_ADDR:   v = c.dst_addr;
        REG_SRC_PORT:   v = {16'h0000, c.src_port};
        REG_DST_PORT:   v = {16'h0000, c.dst_port};
        REG_DEVICE_ID:  v = {24'h000000, c.device_id};
        REG_TTL:        v = {24'h000000, c.ttl};
        REG_IDENT:      v = {16'h0000, c.ident};
        default:        v = {16'h0000, c.flags_frag};
      endcase
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= v;
      idx = idx.next();
    end while (idx != idx.first());
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.regs = c;
  endtask

  // Extremes, all-escape payloads and a report whose UDP checksum folds to zero.
  task automatic directed_burst();
    send_report(32'h00000000);
    send_report(32'hFFFFFFFF);
    send_report(32'hC0DBC0DB);
    send_report(32'hDBC0DBC0);
    send_report(sb.zero_udp_report());
  endtask

  initial begin
    cfg_t c;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values, no idling.
    directed_burst();
    send_report(32'h04030201);
    send_report(32'h80808080);
    send_report(32'h7F7F7F7F);
    send_report(32'hC0C0C0C0);
    send_report(32'hDBDBDBDB);
    drain_results();

    // All registers at zero.
    c = '0;
    apply_config(c);
    directed_burst();
    drain_results();

    // All registers at their maximum.
    c = '1;
    apply_config(c);
    directed_burst();
    drain_results();

    // Header full of END and ESC bytes.
    c.src_addr   = 32'hC0DBC0DB;
    c.dst_addr   = 32'hDBC0DB00;
    c.src_port   = 16'hC0DB;
    c.dst_port   = 16'hDBC0;
    c.device_id  = SLIP_END;
    c.ttl        = SLIP_ESC;
    c.ident      = 16'hC0C0;
    c.flags_frag = 16'hDBDB;
    apply_config(c);
    directed_burst();
    drain_results();

    // Random phases, cycling through the idling patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      c = {pick_report(), pick_report(), pick_byte(), pick_byte(), pick_byte(),
           pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
           pick_byte(), pick_byte()};
      apply_config(c);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // Long receiver hold-off while reports keep coming: fills the queue.
      if (p == 0)
        hold_left = HOLD_OFF_CYCLES;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Mid-phase pause until the block has emptied.
        if (p == 5 && i == ITEMS_PER_PHASE / 2)
          drain_results();
        send_report(pick_report());
      end
      drain_results();
    end

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
